FILE: src/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Types and constants shared by the speed step controller and its stages.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int SPD_W   = 5;   // speed fields
  localparam int ERR_W   = 6;   // error, -31..31
  localparam int DER_W   = 7;   // derivative, -62..62
  localparam int INTEG_W = 11;  // clamped integral, -1023..1023
  localparam int LIM_W   = 10;  // windup limit
  localparam int GAIN_W  = 16;  // Q8.8 gains
  localparam int PWM_W   = 11;
  localparam int FRAC_W  = 8;   // fraction bits of the gains

  localparam int PP_W  = GAIN_W + 1 + ERR_W;    // proportional product
  localparam int IP_W  = GAIN_W + 1 + INTEG_W;  // integral product
  localparam int DP_W  = GAIN_W + 1 + DER_W;    // derivative product
  localparam int ACC_W = IP_W + 1;
  localparam int ADJ_W = ACC_W - FRAC_W;
  localparam int SUM_W = ADJ_W + 1;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_LIMIT = 8'd3;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST    = 16'd256;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST   = 16'd26;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST   = 16'd13;
  localparam logic [LIM_W-1:0]  WINDUP_LIMIT_RST = 10'd100;

  localparam logic [PWM_W-1:0] PWM_BASE    = 11'd1000;
  localparam logic [PWM_W-1:0] PWM_STEP    = 11'd50;
  localparam logic [SPD_W-1:0] PWM_MAP_TOP = 5'd20;

  typedef struct packed {
    logic [SPD_W-1:0] measured_speed;
    logic [SPD_W-1:0] target_speed;
  } pss_in_t;

  typedef struct packed {
    logic [SPD_W-1:0] next_speed;
    logic [PWM_W-1:0] pwm_value;
  } pss_out_t;

  // terms handed from the error stage to the multiply stage
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DER_W-1:0]   deriv;
  } pss_term_t;

  // controller state, visible for checking
  typedef struct packed {
    logic signed [INTEG_W-1:0] integral_sum;
    logic signed [ERR_W-1:0]   prior_error;
  } pss_state_t;

  typedef struct packed {
    logic signed [PP_W-1:0] p_prod;
    logic signed [IP_W-1:0] i_prod;
    logic signed [DP_W-1:0] d_prod;
    logic [SPD_W-1:0]       cur;
    logic [SPD_W-1:0]       tgt;
  } pss_prod_t;

  typedef struct packed {
    logic gains;   // product stage loads
    logic result;  // result stage loads
  } pss_ctrl_t;

endpackage

FILE: src/pss_integ.sv
// ----------------------------------------------------------------------------
// pss_integ
// Error, clamped integral and derivative; holds the integral and prior error.
// ----------------------------------------------------------------------------
module pss_integ import pss_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  pss_in_t          item,
  input  logic [LIM_W-1:0] windup_limit,
  output pss_term_t        term,
  output pss_state_t       state
);

  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   prior_r;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W:0]   sum;
  logic signed [INTEG_W:0]   lim;
  logic signed [INTEG_W:0]   neg_lim;

  always_comb begin
    err = $signed({1'b0, item.target_speed}) - $signed({1'b0, item.measured_speed});
    sum = {{(INTEG_W + 1 - ERR_W){err[ERR_W-1]}}, err} + {integ_r[INTEG_W-1], integ_r};
    lim = $signed({{(INTEG_W + 1 - LIM_W){1'b0}}, windup_limit});
    neg_lim = -lim;
    // anti-windup clamp
    if (sum > lim) begin
      integ_nxt = lim[INTEG_W-1:0];
    end else if (sum < neg_lim) begin
      integ_nxt = neg_lim[INTEG_W-1:0];
    end else begin
      integ_nxt = sum[INTEG_W-1:0];
    end
    term.err   = err;
    term.integ = integ_nxt;
    term.deriv = {err[ERR_W-1], err} - {prior_r[ERR_W-1], prior_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prior_r <= '0;
    end else if (adv) begin
      integ_r <= integ_nxt;
      prior_r <= err;
    end
  end

  assign state.integral_sum = integ_r;
  assign state.prior_error  = prior_r;

endmodule

FILE: src/pss_mul.sv
// ----------------------------------------------------------------------------
// pss_mul
// Gain multiply stage: three small products, registered.
// ----------------------------------------------------------------------------
module pss_mul import pss_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  pss_term_t         term,
  input  pss_in_t           item,
  input  logic [GAIN_W-1:0] prop_gain,
  input  logic [GAIN_W-1:0] integ_gain,
  input  logic [GAIN_W-1:0] deriv_gain,
  output pss_prod_t         prod
);

  pss_prod_t prod_r, prod_nxt;

  always_comb begin
    prod_nxt.p_prod = $signed({1'b0, prop_gain})  * term.err;
    prod_nxt.i_prod = $signed({1'b0, integ_gain}) * term.integ;
    prod_nxt.d_prod = $signed({1'b0, deriv_gain}) * term.deriv;
    prod_nxt.cur    = item.measured_speed;
    prod_nxt.tgt    = item.target_speed;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

FILE: src/pss_out.sv
// ----------------------------------------------------------------------------
// pss_out
// Sum and truncate the adjustment, clamp the speed, map to pwm; result register.
// ----------------------------------------------------------------------------
module pss_out import pss_pkg::*; (
  input  logic      clk,
  input  logic      load,
  input  pss_prod_t prod,
  output pss_out_t  data
);

  pss_out_t                data_r, data_nxt;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_b;
  logic signed [ADJ_W-1:0] adj;
  logic signed [SUM_W-1:0] spd;
  logic signed [SUM_W-1:0] tgt_x;
  logic [SPD_W-1:0]        sel;

  always_comb begin
    acc = ACC_W'(prod.p_prod) + ACC_W'(prod.i_prod) + ACC_W'(prod.d_prod);
    // bias negatives so the shift truncates toward zero
    acc_b = acc + $signed({{(ACC_W - FRAC_W){1'b0}}, {FRAC_W{acc[ACC_W-1]}}});
    adj   = acc_b[ACC_W-1:FRAC_W];
    spd   = $signed({{(SUM_W - SPD_W){1'b0}}, prod.cur}) + {adj[ADJ_W-1], adj};
    tgt_x = $signed({{(SUM_W - SPD_W){1'b0}}, prod.tgt});
    if (spd > tgt_x) begin
      sel = prod.tgt;
    end else if (spd[SUM_W-1]) begin
      sel = '0;
    end else begin
      sel = spd[SPD_W-1:0];
    end
    data_nxt.next_speed = sel;
    if (!sel[0] && sel <= PWM_MAP_TOP) begin
      data_nxt.pwm_value = PWM_BASE + PWM_W'(sel) * PWM_STEP;
    end else begin
      data_nxt.pwm_value = PWM_BASE;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign data = data_r;

endmodule

FILE: src/pid_speed_step_with_pwm_map.sv
// ----------------------------------------------------------------------------
// pid_speed_step_with_pwm_map
// PID speed step with integral clamp and a speed-to-pwm map.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per control step, measured and target speed.
//   out_* : one word per input word, new speed and its pwm value, in order.
//   cfg_* : register writes (index 0..3: prop, integ, deriv gain, windup
//           limit); cfg_ready is always high, other indexes are dropped.
//           Write only while the pipeline is empty.
// Pipeline: three register stages (input, gain products, result); a result
//   shows on out_* after its word passes the product and result registers.
// Throughput: one word per cycle without stalls; integral and prior error
//   update in the first stage, so back-to-back words see each other's state.
// Reset clears the pipeline, the integral and prior error, and loads the
//   default gains (1.0, ~0.1, ~0.05) and a windup limit of 100.
// When out_ready is low the result holds; earlier stages keep filling, and
//   in_ready drops once all three stages are full.
// ----------------------------------------------------------------------------
module pid_speed_step_with_pwm_map import pss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pss_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pss_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [LIM_W-1:0]  windup_limit_r;

  logic       a_v_r, a_v_nxt;
  logic       b_v_r, b_v_nxt;
  logic       c_v_r, c_v_nxt;
  pss_in_t    a_data_r;
  logic       ready_b, ready_c;
  pss_ctrl_t  ctrl;
  pss_term_t  term;
  pss_state_t st;
  pss_prod_t  prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= PROP_GAIN_RST;
      integ_gain_r   <= INTEG_GAIN_RST;
      deriv_gain_r   <= DERIV_GAIN_RST;
      windup_limit_r <= WINDUP_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP_GAIN:    prop_gain_r    <= cfg_data;
        REG_INTEG_GAIN:   integ_gain_r   <= cfg_data;
        REG_DERIV_GAIN:   deriv_gain_r   <= cfg_data;
        REG_WINDUP_LIMIT: windup_limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // stage flow control
  assign ready_c     = !c_v_r || out_ready;
  assign ready_b     = !b_v_r || ready_c;
  assign in_ready    = !a_v_r || ready_b;
  assign ctrl.gains  = a_v_r && ready_b;
  assign ctrl.result = b_v_r && ready_c;

  always_comb begin
    a_v_nxt = in_ready ? in_valid : a_v_r;
    b_v_nxt = ready_b  ? a_v_r    : b_v_r;
    c_v_nxt = ready_c  ? b_v_r    : c_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
      c_v_r <= c_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_data_r <= in_data;
    end
  end

  pss_integ u_integ (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (ctrl.gains),
    .item         (a_data_r),
    .windup_limit (windup_limit_r),
    .term         (term),
    .state        (st)
  );

  pss_mul u_mul (
    .clk        (clk),
    .load       (ctrl.gains),
    .term       (term),
    .item       (a_data_r),
    .prop_gain  (prop_gain_r),
    .integ_gain (integ_gain_r),
    .deriv_gain (deriv_gain_r),
    .prod       (prod)
  );

  pss_out u_out (
    .clk  (clk),
    .load (ctrl.result),
    .prod (prod),
    .data (out_data)
  );

  assign out_valid = c_v_r;

  // controller state moves only when a word leaves the first stage
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !ctrl.gains |=> $stable(st))
    else $error("controller state changed without a word advancing");

  // a full pipeline under a stalled output takes no new word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && b_v_r && c_v_r && !out_ready |-> !in_ready)
    else $error("input accepted with all stages full");

  // odd speeds map to the base pulse width
  a_odd_pwm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.next_speed[0] |-> out_data.pwm_value == PWM_BASE)
    else $error("odd speed with non-base pwm");

  // result stage never loads from an empty product stage
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.result |=> out_valid)
    else $error("result load without valid output");

endmodule
